>>> sv/pfa_pkg.sv
// Package for the page frame allocator/translator: sizes, codes, payload and control types.
`default_nettype none
package pfa_pkg;

  localparam int PAGE_BYTES = 128;
  localparam int FRAMES     = 128;
  localparam int SPACES     = 4;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int SP_IDX_W   = (SPACES > 1) ? $clog2(SPACES) : 1;
  localparam int CNT_W      = $clog2(FRAMES + 1);
  localparam int MEM_AW     = SP_IDX_W + FRAME_W;

  localparam int FUNC_W = 2;
  localparam int SPID_W = 2;
  localparam int SEG_W  = 15;
  localparam int VA_W   = 32;
  localparam int STAT_W = 3;
  localparam int PA_W   = 14;
  localparam int PC_W   = 8;
  localparam int TOP_W  = 14;
  localparam int FF_W   = 8;

  localparam int SUM_W     = SEG_W + 2;
  localparam int REQ_W     = SUM_W - PAGE_SHIFT;
  localparam int VPN_W     = VA_W - PAGE_SHIFT;
  localparam int STACK_GAP = 16;

  localparam logic [SEG_W-1:0] STACK_RESET = 15'd1024;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_STACK_BYTES = 1'b0;

  localparam logic [FUNC_W-1:0] FN_LOAD      = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TRANSLATE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE   = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_ADDR  = 3'd1,
    STAT_BUS   = 3'd2,
    STAT_LIMIT = 3'd3,
    STAT_BUSY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TR_RD,
    S_ALLOC,
    S_REL_RD,
    S_REL_FREE,
    S_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LATCH,
    DP_START,
    DP_ALLOC_STEP,
    DP_TR_FIN,
    DP_REL_RD,
    DP_REL_FREE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SPID_W-1:0] space_id;
    logic [SEG_W-1:0]  segment_bytes;
    logic [VA_W-1:0]   virt_addr;
    logic              is_write;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PA_W-1:0]   phys_addr;
    logic [PC_W-1:0]   page_count;
    logic [TOP_W-1:0]  stack_top;
    logic [FF_W-1:0]   free_frames;
  } out_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               use_mark;
    logic               dirty_mark;
  } pte_t;

  typedef struct packed {
    dp_op_t  op;
    logic    st_wr;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic              sp_ok;
    logic [FUNC_W-1:0] func;
    logic              busy;
    logic              limit;
    logic              zero_req;
    logic              tr_err;
    logic              pfn_bad;
    logic              alloc_last;
    logic              rel_last;
    logic              out_full;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> sv/pfa_ctrl.sv
// Controller state machine for the page frame allocator/translator.
`default_nettype none
module pfa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  pfa_pkg::dp_stat_t     stat,
  output pfa_pkg::dp_cmd_t      cmd
);

  pfa_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pfa_pkg::S_DECODE;
      end
      pfa_pkg::S_DECODE: begin
        state_nxt = pfa_pkg::S_OUT;
        if (stat.sp_ok) begin
          case (stat.func)
            pfa_pkg::FN_LOAD: begin
              if (!stat.busy && !stat.limit && !stat.zero_req) state_nxt = pfa_pkg::S_ALLOC;
            end
            pfa_pkg::FN_TRANSLATE: begin
              if (!stat.tr_err) state_nxt = pfa_pkg::S_TR_RD;
            end
            pfa_pkg::FN_RELEASE: begin
              if (stat.busy) state_nxt = pfa_pkg::S_REL_RD;
            end
            default: state_nxt = pfa_pkg::S_OUT;
          endcase
        end
      end
      pfa_pkg::S_TR_RD:   state_nxt = pfa_pkg::S_OUT;
      pfa_pkg::S_ALLOC: begin
        if (stat.alloc_last) state_nxt = pfa_pkg::S_OUT;
      end
      pfa_pkg::S_REL_RD:  state_nxt = pfa_pkg::S_REL_FREE;
      pfa_pkg::S_REL_FREE: begin
        state_nxt = stat.rel_last ? pfa_pkg::S_OUT : pfa_pkg::S_REL_RD;
      end
      pfa_pkg::S_OUT: begin
        if (!stat.out_full) state_nxt = pfa_pkg::S_IDLE;
      end
      default: state_nxt = pfa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op    = pfa_pkg::DP_IDLE;
    cmd.st_wr = 1'b0;
    cmd.st    = pfa_pkg::STAT_OK;
    in_ready  = 1'b0;
    case (state_r)
      pfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = pfa_pkg::DP_LATCH;
      end
      pfa_pkg::S_DECODE: begin
        cmd.op = pfa_pkg::DP_START;
        if (!stat.sp_ok) begin
          cmd.st_wr = 1'b1;
          cmd.st    = pfa_pkg::STAT_ADDR;
        end else begin
          case (stat.func)
            pfa_pkg::FN_LOAD: begin
              if (stat.busy) begin
                cmd.st_wr = 1'b1;
                cmd.st    = pfa_pkg::STAT_BUSY;
              end else if (stat.limit) begin
                cmd.st_wr = 1'b1;
                cmd.st    = pfa_pkg::STAT_LIMIT;
              end else if (stat.zero_req) begin
                cmd.st_wr = 1'b1;
                cmd.st    = pfa_pkg::STAT_OK;
              end
            end
            pfa_pkg::FN_TRANSLATE: begin
              if (stat.tr_err) begin
                cmd.st_wr = 1'b1;
                cmd.st    = pfa_pkg::STAT_ADDR;
              end
            end
            pfa_pkg::FN_RELEASE: begin
              if (!stat.busy) begin
                cmd.st_wr = 1'b1;
                cmd.st    = pfa_pkg::STAT_OK;
              end
            end
            default: begin
              cmd.st_wr = 1'b1;
              cmd.st    = pfa_pkg::STAT_ADDR;
            end
          endcase
        end
      end
      pfa_pkg::S_TR_RD: begin
        cmd.st_wr = 1'b1;
        if (stat.pfn_bad) begin
          cmd.st = pfa_pkg::STAT_BUS;
        end else begin
          cmd.op = pfa_pkg::DP_TR_FIN;
          cmd.st = pfa_pkg::STAT_OK;
        end
      end
      pfa_pkg::S_ALLOC: begin
        cmd.op = pfa_pkg::DP_ALLOC_STEP;
        if (stat.alloc_last) begin
          cmd.st_wr = 1'b1;
          cmd.st    = pfa_pkg::STAT_OK;
        end
      end
      pfa_pkg::S_REL_RD: cmd.op = pfa_pkg::DP_REL_RD;
      pfa_pkg::S_REL_FREE: begin
        cmd.op = pfa_pkg::DP_REL_FREE;
        if (stat.rel_last) begin
          cmd.st_wr = 1'b1;
          cmd.st    = pfa_pkg::STAT_OK;
        end
      end
      pfa_pkg::S_OUT: begin
        if (!stat.out_full) cmd.op = pfa_pkg::DP_EMIT;
      end
      default: cmd.op = pfa_pkg::DP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/pfa_dp.sv
// Datapath: frame map, free count, page table memory, page counts and result register.
`default_nettype none
module pfa_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  pfa_pkg::in_item_t               in_data,
  input  wire logic [pfa_pkg::SEG_W-1:0]  stack_bytes,
  input  pfa_pkg::dp_cmd_t                cmd,
  output pfa_pkg::dp_stat_t               stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output pfa_pkg::out_item_t              out_data
);

  // control state
  logic [pfa_pkg::FRAMES-1:0] frame_used_r;
  logic [pfa_pkg::CNT_W-1:0]  free_count_r;
  logic [pfa_pkg::CNT_W-1:0]  pages_held_r [pfa_pkg::SPACES];
  logic                       out_valid_r;

  // latched item and work registers
  logic [pfa_pkg::FUNC_W-1:0]  func_r;
  logic [pfa_pkg::SPID_W-1:0]  sp_r;
  logic [pfa_pkg::SEG_W-1:0]   seg_r;
  logic [pfa_pkg::VA_W-1:0]    va_r;
  logic                        wr_r;
  logic [pfa_pkg::FRAME_W-1:0] fptr_r;
  logic [pfa_pkg::FRAME_W-1:0] page_r;
  pfa_pkg::status_t            status_r;
  logic [pfa_pkg::PA_W-1:0]    phys_r;
  pfa_pkg::out_item_t          out_r;

  // page table
  pfa_pkg::pte_t mem [2**pfa_pkg::MEM_AW];
  pfa_pkg::pte_t rdata_r;
  logic                        mem_we;
  logic [pfa_pkg::MEM_AW-1:0]  mem_waddr;
  pfa_pkg::pte_t               mem_wdata;
  logic [pfa_pkg::MEM_AW-1:0]  rd_addr;

  logic [pfa_pkg::SP_IDX_W-1:0] sp_idx;
  logic [pfa_pkg::CNT_W-1:0]    held;
  logic [pfa_pkg::SUM_W-1:0]    size_sum;
  logic [pfa_pkg::REQ_W-1:0]    pages_req;
  logic [pfa_pkg::VPN_W-1:0]    vpn;
  logic [pfa_pkg::PAGE_SHIFT-1:0] off;
  logic [pfa_pkg::MEM_AW-1:0]   page_addr;
  logic [pfa_pkg::MEM_AW-1:0]   vpn_addr;
  logic                         sp_ok;
  logic                         frame_free;
  logic                         alloc_last;
  logic                         rel_hit;
  logic                         rel_last;

  assign sp_idx    = pfa_pkg::SP_IDX_W'(sp_r);
  assign sp_ok     = (32'(sp_r) < pfa_pkg::SPACES);
  assign held      = pages_held_r[sp_idx];
  assign size_sum  = pfa_pkg::SUM_W'(seg_r) + pfa_pkg::SUM_W'(stack_bytes)
                   + pfa_pkg::SUM_W'(pfa_pkg::PAGE_BYTES - 1);
  assign pages_req = size_sum[pfa_pkg::SUM_W-1:pfa_pkg::PAGE_SHIFT];
  assign vpn       = va_r[pfa_pkg::VA_W-1:pfa_pkg::PAGE_SHIFT];
  assign off       = va_r[pfa_pkg::PAGE_SHIFT-1:0];
  assign page_addr = {sp_idx, page_r};
  assign vpn_addr  = {sp_idx, vpn[pfa_pkg::FRAME_W-1:0]};
  assign rd_addr   = (cmd.op == pfa_pkg::DP_REL_RD) ? page_addr : vpn_addr;

  assign frame_free = !frame_used_r[fptr_r];
  assign alloc_last = frame_free && ((32'(page_r) + 1) == 32'(pages_req));
  assign rel_hit    = (32'(rdata_r.frame) < pfa_pkg::FRAMES) && frame_used_r[rdata_r.frame];
  assign rel_last   = ((32'(page_r) + 1) >= 32'(held))
                   || ((32'(page_r) + 1) >= pfa_pkg::FRAMES);

  always_comb begin
    stat.sp_ok      = sp_ok;
    stat.func       = func_r;
    stat.busy       = (held != '0);
    stat.limit      = (32'(pages_req) > 32'(free_count_r)) || (32'(pages_req) > pfa_pkg::FRAMES);
    stat.zero_req   = (pages_req == '0);
    stat.tr_err     = (32'(vpn) >= 32'(held)) || (32'(vpn) >= pfa_pkg::FRAMES);
    stat.pfn_bad    = (32'(rdata_r.frame) >= pfa_pkg::FRAMES);
    stat.alloc_last = alloc_last;
    stat.rel_last   = rel_last;
    stat.out_full   = out_valid_r && !out_ready;
  end

  // page table write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = page_addr;
    mem_wdata = rdata_r;
    case (cmd.op)
      pfa_pkg::DP_ALLOC_STEP: begin
        mem_we    = frame_free;
        mem_wdata = '{frame: fptr_r, use_mark: 1'b0, dirty_mark: 1'b0};
      end
      pfa_pkg::DP_TR_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = vpn_addr;
        mem_wdata = '{frame: rdata_r.frame, use_mark: 1'b1,
                      dirty_mark: rdata_r.dirty_mark | wr_r};
      end
      pfa_pkg::DP_REL_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = '{frame: rdata_r.frame, use_mark: 1'b0, dirty_mark: 1'b0};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  // frame map, free count, page counts, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_used_r <= '0;
      free_count_r <= pfa_pkg::CNT_W'(pfa_pkg::FRAMES);
      for (int s = 0; s < pfa_pkg::SPACES; s++) pages_held_r[s] <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == pfa_pkg::DP_ALLOC_STEP && frame_free) begin
        frame_used_r[fptr_r] <= 1'b1;
        free_count_r         <= free_count_r - 1'b1;
        if (alloc_last) pages_held_r[sp_idx] <= pfa_pkg::CNT_W'(pages_req);
      end
      if (cmd.op == pfa_pkg::DP_REL_FREE) begin
        if (rel_hit) begin
          frame_used_r[rdata_r.frame] <= 1'b0;
          free_count_r                <= free_count_r + 1'b1;
        end
        if (rel_last) pages_held_r[sp_idx] <= '0;
      end
      if (cmd.op == pfa_pkg::DP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pfa_pkg::DP_LATCH: begin
        func_r <= in_data.func;
        sp_r   <= in_data.space_id;
        seg_r  <= in_data.segment_bytes;
        va_r   <= in_data.virt_addr;
        wr_r   <= in_data.is_write;
        phys_r <= '0;
      end
      pfa_pkg::DP_START: begin
        fptr_r <= '0;
        page_r <= '0;
      end
      pfa_pkg::DP_ALLOC_STEP: begin
        fptr_r <= fptr_r + 1'b1;
        if (frame_free) page_r <= page_r + 1'b1;
      end
      pfa_pkg::DP_TR_FIN: begin
        phys_r <= pfa_pkg::PA_W'({rdata_r.frame, off});
      end
      pfa_pkg::DP_REL_FREE: begin
        page_r <= page_r + 1'b1;
      end
      pfa_pkg::DP_EMIT: begin
        out_r.status      <= status_r;
        out_r.phys_addr   <= phys_r;
        out_r.page_count  <= sp_ok ? pfa_pkg::PC_W'(held) : '0;
        out_r.stack_top   <= (sp_ok && held != '0)
          ? pfa_pkg::TOP_W'((32'(held) << pfa_pkg::PAGE_SHIFT) - pfa_pkg::STACK_GAP)
          : '0;
        out_r.free_frames <= pfa_pkg::FF_W'(free_count_r);
      end
      default: fptr_r <= fptr_r;
    endcase
    if (cmd.st_wr) status_r <= cmd.st;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

>>> sv/page_frame_allocator_translator_top.sv
// Top level of the page frame allocator/translator: register port, controller and datapath.
`default_nettype none
//
//  Channel   Direction  Handshake               Payload
//  in_       input      in_valid / in_ready     pfa_pkg::in_item_t  (func, space, size, va, wr)
//  out_      output     out_valid / out_ready   pfa_pkg::out_item_t (status, pa, pages, sp, free)
//  APB       config     psel/penable/pready     stack_bytes at byte address 0
//
//  One item at a time. Translate steps, from transfer to result register: latch,
//  decode + table read, mark update, result. Load: latch, decode, the first-free walk
//  (one frame map bit a cycle, at most FRAMES), result. Release: latch, decode, then per
//  held page a table read and then a frame free, result. Errors and empty cases: latch, decode, result.
//  Synchronous active-low reset clears the frame map, free count and page counts at once;
//  the page table needs no clearing. A held result does not block the next input transfer;
//  a new result waits in the final state until the output register is free.
//
module page_frame_allocator_translator_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  pfa_pkg::in_item_t                in_data,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output pfa_pkg::out_item_t               out_data,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfa_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [pfa_pkg::CFG_DW-1:0]  pwdata,
  output logic [pfa_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);

  logic [pfa_pkg::SEG_W-1:0] stack_bytes_r;
  logic                      reg_sel;
  pfa_pkg::dp_cmd_t          cmd;
  pfa_pkg::dp_stat_t         stat;

  // single register at word 0; address bit 2 picks the word, low bits ignored
  assign reg_sel = (paddr[2] == pfa_pkg::REG_STACK_BYTES);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? pfa_pkg::CFG_DW'(stack_bytes_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_bytes_r <= pfa_pkg::STACK_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      stack_bytes_r <= pwdata[pfa_pkg::SEG_W-1:0];
    end
  end

  // sequencing: decode, table walk, frame map walk, result handoff
  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state and arithmetic: frame map, page table memory, counts, result register
  pfa_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .stack_bytes (stack_bytes_r),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
